@@ src/bfrf_pkg.sv @@
// shared types and constants of the brace fold region finder
package bfrf_pkg;

    localparam int CODE_W = 21;
    localparam int LINE_W = 20;
    localparam int COL_W = 16;
    localparam int MAX_PAIRS = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [LINE_W-1:0] line_t;
    typedef logic [COL_W-1:0] col_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAIR_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_B = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_C = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_C = 3'd6;

    localparam logic [1:0] PAIR_COUNT_RESET = 2'd1;
    localparam code_t OPEN_RESET [MAX_PAIRS] = '{21'd123, 21'd91, 21'd40};
    localparam code_t CLOSE_RESET [MAX_PAIRS] = '{21'd125, 21'd93, 21'd41};

    // stack action of one brace pair for one character
    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_PUSH,
        ACT_POP
    } act_t;

    // one stack entry: position of an opening brace
    typedef struct packed {
        line_t line;
        col_t  column;
    } pos_t;

    typedef struct packed {
        line_t start_line;
        col_t  start_column;
        line_t end_line;
        col_t  end_column;
        logic  overflow;
    } region_t;

endpackage

@@ src/bfrf_stack_ram.sv @@
// synchronous single-write single-read memory holding the open brace stack
module bfrf_stack_ram #(
    parameter int DEPTH = 64
) (
    input  logic                   clk,
    input  logic                   we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  bfrf_pkg::pos_t         wdata,
    input  logic                   re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output bfrf_pkg::pos_t         rdata
);

    bfrf_pkg::pos_t mem [DEPTH];
    bfrf_pkg::pos_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/brace_fold_region_finder_top.sv @@
// top level of the brace fold region finder: decode, stack sequencer, region output
//
// One character is taken per cycle when it matches at most one configured brace
// pair and no pop waits on a stalled compare stage; a character matching several
// pairs holds the input until its last action, as the stack memory does exactly
// one push or one pop per cycle. A closer that yields two or more regions hands
// out its final region from the held register. Regions pass the memory read and
// line compare, then an output register before the downstream stall. The stack
// is a STACK_DEPTH-entry synchronous memory; no clearing pass is needed after reset.
module brace_fold_region_finder_top #(
    parameter int STACK_DEPTH = 64,
    parameter int PAIR_SLOTS = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [bfrf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bfrf_pkg::CODE_W-1:0]       cfg_data,
    // character input
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bfrf_pkg::CODE_W-1:0]       char_code,
    input  logic [bfrf_pkg::LINE_W-1:0]       line_index,
    input  logic [bfrf_pkg::COL_W-1:0]        column_index,
    input  logic                              in_string_or_comment,
    // region output
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [bfrf_pkg::LINE_W-1:0]       start_line,
    output logic [bfrf_pkg::COL_W-1:0]        start_column,
    output logic [bfrf_pkg::LINE_W-1:0]       end_line,
    output logic [bfrf_pkg::COL_W-1:0]        end_column,
    output logic                              overflow_seen,
    output logic                              last_of_run
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int FW = $clog2(STACK_DEPTH + 1);

    // configuration registers
    logic [1:0]      pair_count_reg;
    bfrf_pkg::code_t open_reg [bfrf_pkg::MAX_PAIRS];
    bfrf_pkg::code_t close_reg [bfrf_pkg::MAX_PAIRS];

    // stack control
    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [FW-1:0] fill_m1;
    logic          overflow_reg;
    logic          overflow_next;

    // execute stage: one character with its pending actions
    logic              x_valid_reg;
    bfrf_pkg::act_t    x_act_reg [PAIR_SLOTS];
    bfrf_pkg::line_t   x_line_reg;
    bfrf_pkg::col_t    x_col_reg;
    bfrf_pkg::act_t    dec_act [PAIR_SLOTS];
    logic              dec_any;
    logic [PAIR_SLOTS-1:0] sel;
    bfrf_pkg::act_t    cur_act;
    logic              seen;
    logic              rest_any;
    logic              pop_later;
    logic              x_exec;
    logic              x_done;
    logic              x_push;
    logic              x_pop;
    logic              accept;

    // compare stage: popped entry against the closer
    logic              r_valid_reg;
    logic              r_hit_reg;
    logic              r_last_reg;
    logic              r_ovf_reg;
    bfrf_pkg::line_t   r_line_reg;
    bfrf_pkg::col_t    r_col_reg;
    logic              r_adv;
    logic              r_free;
    logic              emit;
    bfrf_pkg::region_t new_region;

    // held region whose last flag is not known yet
    logic              h_valid_reg;
    logic              h_valid_next;
    logic              h_final_reg;
    logic              h_final_next;
    bfrf_pkg::region_t h_reg;
    bfrf_pkg::region_t h_next;

    // output register
    logic              out_valid_reg;
    logic              out_last_reg;
    bfrf_pkg::region_t out_reg;
    logic              out_free;
    logic              load_out;
    logic              load_last;
    bfrf_pkg::region_t load_region;

    // memory ports
    logic            ram_we;
    logic            ram_re;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    bfrf_pkg::pos_t  ram_wdata;
    bfrf_pkg::pos_t  ram_rdata;

    bfrf_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_count_reg <= bfrf_pkg::PAIR_COUNT_RESET;
            open_reg <= bfrf_pkg::OPEN_RESET;
            close_reg <= bfrf_pkg::CLOSE_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bfrf_pkg::CFG_PAIR_COUNT: pair_count_reg <= cfg_data[1:0];
                bfrf_pkg::CFG_OPEN_A:     open_reg[0] <= cfg_data;
                bfrf_pkg::CFG_CLOSE_A:    close_reg[0] <= cfg_data;
                bfrf_pkg::CFG_OPEN_B:     open_reg[1] <= cfg_data;
                bfrf_pkg::CFG_CLOSE_B:    close_reg[1] <= cfg_data;
                bfrf_pkg::CFG_OPEN_C:     open_reg[2] <= cfg_data;
                bfrf_pkg::CFG_CLOSE_C:    close_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // decode the character against each pair in use; opener test wins
    always_comb
    begin
        dec_any = 1'b0;
        for (int p = 0; p < PAIR_SLOTS; p++)
        begin
            dec_act[p] = bfrf_pkg::ACT_NONE;
            if (!in_string_or_comment && (2'(p) < pair_count_reg))
            begin
                if (char_code == open_reg[p])
                begin
                    dec_act[p] = bfrf_pkg::ACT_PUSH;
                end
                else if (char_code == close_reg[p])
                begin
                    dec_act[p] = bfrf_pkg::ACT_POP;
                end
            end
            if (dec_act[p] != bfrf_pkg::ACT_NONE)
            begin
                dec_any = 1'b1;
            end
        end
    end

    // pick the first pending action of the character
    always_comb
    begin
        seen = 1'b0;
        rest_any = 1'b0;
        pop_later = 1'b0;
        cur_act = bfrf_pkg::ACT_NONE;
        sel = '0;
        for (int p = 0; p < PAIR_SLOTS; p++)
        begin
            if (x_act_reg[p] != bfrf_pkg::ACT_NONE)
            begin
                if (!seen)
                begin
                    sel[p] = 1'b1;
                    cur_act = x_act_reg[p];
                end
                else
                begin
                    rest_any = 1'b1;
                    if (x_act_reg[p] == bfrf_pkg::ACT_POP)
                    begin
                        pop_later = 1'b1;
                    end
                end
                seen = 1'b1;
            end
        end
    end

    assign x_exec = x_valid_reg && ((cur_act != bfrf_pkg::ACT_POP) || r_free);
    assign x_done = x_exec && !rest_any;
    assign x_push = x_exec && (cur_act == bfrf_pkg::ACT_PUSH);
    assign x_pop = x_exec && (cur_act == bfrf_pkg::ACT_POP);
    assign in_stall = x_valid_reg && !x_done;
    assign accept = in_valid && !in_stall;
    assign fill_m1 = fill_reg - FW'(1);

    // stack pointer and memory access, one access per cycle
    always_comb
    begin
        fill_next = fill_reg;
        overflow_next = overflow_reg;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_waddr = fill_reg[AW-1:0];
        ram_raddr = fill_m1[AW-1:0];
        ram_wdata = '{line: x_line_reg, column: x_col_reg};
        if (x_push)
        begin
            if (fill_reg < FW'(STACK_DEPTH))
            begin
                ram_we = 1'b1;
                fill_next = fill_reg + FW'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
        end
        else if (x_pop && (fill_reg != '0))
        begin
            ram_re = 1'b1;
            fill_next = fill_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            overflow_reg <= 1'b0;
            x_valid_reg <= 1'b0;
            for (int p = 0; p < PAIR_SLOTS; p++)
            begin
                x_act_reg[p] <= bfrf_pkg::ACT_NONE;
            end
        end
        else
        begin
            fill_reg <= fill_next;
            overflow_reg <= overflow_next;
            if (accept)
            begin
                x_valid_reg <= dec_any;
                x_act_reg <= dec_act;
            end
            else if (x_exec)
            begin
                if (x_done)
                begin
                    x_valid_reg <= 1'b0;
                end
                for (int p = 0; p < PAIR_SLOTS; p++)
                begin
                    if (sel[p])
                    begin
                        x_act_reg[p] <= bfrf_pkg::ACT_NONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_line_reg <= line_index;
            x_col_reg <= column_index;
        end
    end

    // compare stage and region hand-off
    assign out_free = !out_valid_reg || !out_stall;
    assign emit = r_valid_reg && r_hit_reg && (ram_rdata.line != r_line_reg);
    assign new_region = '{start_line: ram_rdata.line, start_column: ram_rdata.column,
                          end_line: r_line_reg, end_column: r_col_reg,
                          overflow: r_ovf_reg};
    assign r_free = !r_valid_reg || r_adv;

    always_comb
    begin
        r_adv = 1'b0;
        load_out = 1'b0;
        load_last = 1'b0;
        load_region = h_reg;
        h_valid_next = h_valid_reg;
        h_final_next = h_final_reg;
        h_next = h_reg;
        if (h_valid_reg && h_final_reg)
        begin
            // flush the final region of a multi-region character
            if (out_free)
            begin
                load_out = 1'b1;
                load_last = 1'b1;
                h_valid_next = 1'b0;
                h_final_next = 1'b0;
            end
        end
        else if (r_valid_reg)
        begin
            if (emit && h_valid_reg)
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    h_next = new_region;
                    h_final_next = r_last_reg;
                    r_adv = 1'b1;
                end
            end
            else if (emit && r_last_reg)
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    load_last = 1'b1;
                    load_region = new_region;
                    r_adv = 1'b1;
                end
            end
            else if (emit)
            begin
                h_valid_next = 1'b1;
                h_next = new_region;
                r_adv = 1'b1;
            end
            else
            begin
                // no region from this pop; the held one is last if no pop follows
                if (r_last_reg && h_valid_reg)
                begin
                    h_final_next = 1'b1;
                end
                r_adv = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            h_final_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (x_pop)
            begin
                r_valid_reg <= 1'b1;
            end
            else if (r_adv)
            begin
                r_valid_reg <= 1'b0;
            end
            h_valid_reg <= h_valid_next;
            h_final_reg <= h_final_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (x_pop)
        begin
            r_hit_reg <= (fill_reg != '0);
            r_last_reg <= !pop_later;
            r_ovf_reg <= overflow_reg;
            r_line_reg <= x_line_reg;
            r_col_reg <= x_col_reg;
        end
        h_reg <= h_next;
        if (load_out)
        begin
            out_reg <= load_region;
            out_last_reg <= load_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign start_line = out_reg.start_line;
    assign start_column = out_reg.start_column;
    assign end_line = out_reg.end_line;
    assign end_column = out_reg.end_column;
    assign overflow_seen = out_reg.overflow;
    assign last_of_run = out_last_reg;

    // stack never holds more than its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(STACK_DEPTH))
        else $error("stack fill beyond depth");

    // overflow flag is sticky
    assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |=> overflow_reg)
        else $error("overflow flag cleared");

    // one memory access per cycle, so a pop never races a push
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("stack read and write in one cycle");

    // a pending final region is always a held one
    assert property (@(posedge clk) disable iff (!rst_n)
        h_final_reg |-> h_valid_reg)
        else $error("final mark without held region");

    // a pop is only issued when the compare stage can take it
    assert property (@(posedge clk) disable iff (!rst_n)
        (r_valid_reg && !r_adv) |=> (r_valid_reg && $stable(r_line_reg)))
        else $error("compare stage overwritten while stalled");

endmodule
